FILE: hw/rtl/gdvc_pkg.sv
// ----------------------------------------------------------------------------
// gdvc_pkg
// Shared constants, types and helper functions of the goal deadband velocity
// controller: angle constants, arctangent table, unit interfaces.
// ----------------------------------------------------------------------------
package gdvc_pkg;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned ATAN_LEN     = 24;
  localparam int unsigned CORDIC_ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int unsigned ITER_W       = (CORDIC_ITERS > 1) ? $clog2(CORDIC_ITERS) : 1;

  localparam int unsigned POS_W  = 32;
  localparam int unsigned HEAD_W = 16;
  localparam int unsigned TOL_W  = 31;
  localparam int unsigned SPD_W  = 16;
  localparam int unsigned SPDS_W = 48;
  localparam int unsigned ANG_W  = 33;
  localparam int unsigned CS_W   = 32;
  localparam int unsigned DIFF_W = 33;
  localparam int unsigned ATAN_W = 28;
  localparam int unsigned HALF_W = 16;
  localparam int unsigned OPA_W  = HALF_W + 1;
  localparam int unsigned PROD_W = OPA_W + DIFF_W;
  localparam int unsigned ACC_W  = 64;
  localparam int unsigned FRAC_W = 28;
  localparam int unsigned ERR_W  = ACC_W - FRAC_W;
  localparam int unsigned EH_W   = HEAD_W + 1;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic signed [ANG_W-1:0] ANG_PI      = 33'sd843314857;
  localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 33'sd1686629713;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 33'sd421657428;
  localparam logic signed [CS_W-1:0]  CORDIC_GAIN = 32'sd163008219;
  localparam logic [SPD_W-1:0]        SPEED_MAX   = 16'h7FFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GOAL_X        = 3'd0,
    REG_GOAL_Y        = 3'd1,
    REG_GOAL_HEADING  = 3'd2,
    REG_TOL_X         = 3'd3,
    REG_TOL_Y         = 3'd4,
    REG_TOL_HEADING   = 3'd5,
    REG_SPEED_SET     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic                   done;
    logic signed [CS_W-1:0] sin;
    logic signed [CS_W-1:0] cos;
  } rot_res_t;

  typedef struct packed {
    logic                     start;
    logic signed [CS_W-1:0]   sin;
    logic signed [CS_W-1:0]   cos;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
  } mac_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ERR_W-1:0] ex;
    logic signed [ERR_W-1:0] ey;
  } mac_res_t;

  function automatic logic [ATAN_W-1:0] atan_q28(input logic [4:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 28'd210828714;
      5'd1:    v = 28'd124459457;
      5'd2:    v = 28'd65760959;
      5'd3:    v = 28'd33381290;
      5'd4:    v = 28'd16755422;
      5'd5:    v = 28'd8385879;
      5'd6:    v = 28'd4193963;
      5'd7:    v = 28'd2097109;
      5'd8:    v = 28'd1048571;
      5'd9:    v = 28'd524287;
      5'd10:   v = 28'd262144;
      5'd11:   v = 28'd131072;
      5'd12:   v = 28'd65536;
      5'd13:   v = 28'd32768;
      5'd14:   v = 28'd16384;
      5'd15:   v = 28'd8192;
      5'd16:   v = 28'd4096;
      5'd17:   v = 28'd2048;
      5'd18:   v = 28'd1024;
      5'd19:   v = 28'd512;
      5'd20:   v = 28'd256;
      5'd21:   v = 28'd128;
      5'd22:   v = 28'd64;
      5'd23:   v = 28'd32;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Zero inside the deadband, otherwise the saturated speed with the error's sign.
  function automatic logic [SPD_W-1:0] drive_axis(input logic signed [ERR_W-1:0] err,
                                                  input logic [TOL_W-1:0] tol,
                                                  input logic [SPD_W-1:0] spd);
    logic [ERR_W-1:0] mag;
    logic [SPD_W-1:0] lim;
    logic [SPD_W-1:0] res;
    mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    lim = spd[SPD_W-1] ? SPEED_MAX : spd;
    if (mag <= ERR_W'(tol)) begin
      res = '0;
    end else if (err[ERR_W-1]) begin
      res = SPD_W'(-lim);
    end else begin
      res = lim;
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/gdvc_cordic.sv
// ----------------------------------------------------------------------------
// gdvc_cordic
// Iterative CORDIC rotator: reduces the heading to the right half plane and
// runs one shared shift-add step per cycle to give sine and cosine in Q.28.
// ----------------------------------------------------------------------------
module gdvc_cordic (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start_i,
  input  logic signed [gdvc_pkg::HEAD_W-1:0]        heading_i,
  output gdvc_pkg::rot_res_t                        res_o
);

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_HALF = 4'b0010,
    C_ITER = 4'b0100,
    C_FIN  = 4'b1000
  } cor_state_e;

  cor_state_e state_q, state_d;

  logic [gdvc_pkg::ITER_W-1:0]         iter_q, iter_d;
  logic signed [gdvc_pkg::ANG_W-1:0]   z_q, z_d;
  logic signed [gdvc_pkg::CS_W-1:0]    x_q, x_d, y_q, y_d;
  logic                                flip_q, flip_d;
  logic                                done_q, done_d;
  logic signed [gdvc_pkg::CS_W-1:0]    sin_q, sin_d, cos_q, cos_d;

  logic signed [gdvc_pkg::ANG_W-1:0]   ang_full;
  logic signed [gdvc_pkg::CS_W-1:0]    xs, ys;
  logic signed [gdvc_pkg::ANG_W-1:0]   atan_ext;

  assign ang_full = {heading_i[gdvc_pkg::HEAD_W-1], heading_i, 16'h0000};
  assign xs       = x_q >>> iter_q;
  assign ys       = y_q >>> iter_q;
  assign atan_ext = $signed(gdvc_pkg::ANG_W'(gdvc_pkg::atan_q28(5'(iter_q))));

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    z_d     = z_q;
    x_d     = x_q;
    y_d     = y_q;
    flip_d  = flip_q;
    done_d  = 1'b0;
    sin_d   = sin_q;
    cos_d   = cos_q;
    case (state_q)
      C_IDLE: begin
        if (start_i) begin
          if (ang_full > gdvc_pkg::ANG_PI) begin
            z_d = ang_full - gdvc_pkg::ANG_TWO_PI;
          end else if (ang_full < -gdvc_pkg::ANG_PI) begin
            z_d = ang_full + gdvc_pkg::ANG_TWO_PI;
          end else begin
            z_d = ang_full;
          end
          state_d = C_HALF;
        end
      end
      C_HALF: begin
        if (z_q > gdvc_pkg::ANG_HALF_PI) begin
          z_d    = z_q - gdvc_pkg::ANG_PI;
          flip_d = 1'b1;
        end else if (z_q < -gdvc_pkg::ANG_HALF_PI) begin
          z_d    = z_q + gdvc_pkg::ANG_PI;
          flip_d = 1'b1;
        end else begin
          flip_d = 1'b0;
        end
        x_d     = gdvc_pkg::CORDIC_GAIN;
        y_d     = '0;
        iter_d  = '0;
        state_d = C_ITER;
      end
      C_ITER: begin
        if (!z_q[gdvc_pkg::ANG_W-1]) begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - atan_ext;
        end else begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + atan_ext;
        end
        iter_d = iter_q + 1'b1;
        if (iter_q == gdvc_pkg::ITER_W'(gdvc_pkg::CORDIC_ITERS - 1)) begin
          state_d = C_FIN;
        end
      end
      C_FIN: begin
        cos_d   = flip_q ? -x_q : x_q;
        sin_d   = flip_q ? -y_q : y_q;
        done_d  = 1'b1;
        state_d = C_IDLE;
      end
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iter_q <= iter_d;
    z_q    <= z_d;
    x_q    <= x_d;
    y_q    <= y_d;
    flip_q <= flip_d;
    sin_q  <= sin_d;
    cos_q  <= cos_d;
  end

  assign res_o.done = done_q;
  assign res_o.sin  = sin_q;
  assign res_o.cos  = cos_q;

endmodule

FILE: hw/rtl/gdvc_mac.sv
// ----------------------------------------------------------------------------
// gdvc_mac
// Shared 17x33 multiplier with two accumulators: rotates the world-frame
// error into the body frame over eight half-word partial products.
// ----------------------------------------------------------------------------
module gdvc_mac (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gdvc_pkg::mac_req_t   req_i,
  output gdvc_pkg::mac_res_t   res_o
);

  logic                                 issue_q;
  logic [2:0]                           k_q;
  logic signed [gdvc_pkg::CS_W-1:0]     cos_q, sin_q, nsin_q;
  logic signed [gdvc_pkg::DIFF_W-1:0]   dx_q, dy_q;
  logic signed [gdvc_pkg::PROD_W-1:0]   p_q;
  logic [2:0]                           pk_q;
  logic                                 pv_q;
  logic signed [gdvc_pkg::ACC_W-1:0]    acc_x_q, acc_y_q;
  logic                                 done_q;

  logic signed [gdvc_pkg::CS_W-1:0]     w;
  logic signed [gdvc_pkg::OPA_W-1:0]    a;
  logic signed [gdvc_pkg::DIFF_W-1:0]   b;
  logic signed [gdvc_pkg::PROD_W-1:0]   prod;
  logic signed [gdvc_pkg::ACC_W-1:0]    p_ext, addend;

  // k[2]: body x or y; k[1]: first or second term; k[0]: low or high half word.
  always_comb begin
    if (!k_q[1]) begin
      w = cos_q;
    end else if (k_q[2]) begin
      w = nsin_q;
    end else begin
      w = sin_q;
    end
    a = k_q[0] ? $signed({w[gdvc_pkg::CS_W-1], w[gdvc_pkg::CS_W-1:gdvc_pkg::HALF_W]})
               : $signed({1'b0, w[gdvc_pkg::HALF_W-1:0]});
    b = (k_q[2] ^ k_q[1]) ? dy_q : dx_q;
    prod = gdvc_pkg::PROD_W'(a) * gdvc_pkg::PROD_W'(b);
  end

  assign p_ext  = gdvc_pkg::ACC_W'(p_q);
  assign addend = pk_q[0] ? (p_ext <<< gdvc_pkg::HALF_W) : p_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      pv_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      pv_q   <= issue_q;
      done_q <= pv_q && (pk_q == 3'd7);
      if (req_i.start) begin
        issue_q <= 1'b1;
      end else if (issue_q && k_q == 3'd7) begin
        issue_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      cos_q   <= req_i.cos;
      sin_q   <= req_i.sin;
      nsin_q  <= -req_i.sin;
      dx_q    <= req_i.dx;
      dy_q    <= req_i.dy;
      k_q     <= '0;
      acc_x_q <= '0;
      acc_y_q <= '0;
    end else begin
      if (issue_q) begin
        k_q <= k_q + 3'd1;
      end
      if (pv_q) begin
        if (pk_q[2]) begin
          acc_y_q <= acc_y_q + addend;
        end else begin
          acc_x_q <= acc_x_q + addend;
        end
      end
    end
    p_q  <= prod;
    pk_q <= k_q;
  end

  assign res_o.done = done_q;
  assign res_o.ex   = acc_x_q[gdvc_pkg::ACC_W-1:gdvc_pkg::FRAC_W];
  assign res_o.ey   = acc_y_q[gdvc_pkg::ACC_W-1:gdvc_pkg::FRAC_W];

endmodule

FILE: hw/rtl/goal_deadband_velocity_controller.sv
// ----------------------------------------------------------------------------
// goal_deadband_velocity_controller
// Bang-bang pose controller with deadband: body-frame goal error via CORDIC
// and a shared multiplier, per-axis drive of zero or plus/minus speed.
// ----------------------------------------------------------------------------
//  channel  | direction | fields
//  s_axis   | in        | tuser: pose_valid; tdata: pos_x, pos_y, heading
//  m_axis   | out       | tuser: arrived; tdata: drive_x, drive_y, drive_yaw
//  cfg      | in        | index 0..6 selects the register, data in the low bits
//
//  A valid pose goes through range reduction, one CORDIC step per cycle, then
//  eight partial products through the single multiplier. An invalid pose goes
//  straight to the output stage.
//  Input is taken again as soon as the result sits in the output register;
//  a stalled output holds the last step until the result is transferred.
//  Reset clears the state, the output valid flag, the configuration registers and the reached flag.
// ----------------------------------------------------------------------------
module goal_deadband_velocity_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // pos_x[31:0], pos_y[63:32], heading[79:64]
  input  logic        s_axis_tuser,   // pose_valid
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // drive_x[15:0], drive_y[31:16], drive_yaw[47:32]
  output logic        m_axis_tuser,   // arrived
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ROT  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_OUT  = 4'b1000
  } top_state_e;

  top_state_e state_q, state_d;

  logic signed [gdvc_pkg::POS_W-1:0]   goal_x_q, goal_y_q;
  logic signed [gdvc_pkg::HEAD_W-1:0]  goal_heading_q;
  logic [gdvc_pkg::TOL_W-1:0]          tol_x_q, tol_y_q;
  logic [gdvc_pkg::HEAD_W-1:0]         tol_heading_q;
  logic [gdvc_pkg::SPDS_W-1:0]         speed_set_q;
  logic                                reached_q;

  logic                                pv_q;
  logic signed [gdvc_pkg::HEAD_W-1:0]  heading_q;
  logic signed [gdvc_pkg::DIFF_W-1:0]  dx_q, dy_q;

  logic                                m_valid_q;
  logic [47:0]                         m_data_q;
  logic                                m_user_q;

  logic signed [gdvc_pkg::POS_W-1:0]   in_x, in_y;
  logic signed [gdvc_pkg::HEAD_W-1:0]  in_h;
  logic                                s_xfer, m_xfer, out_free, cfg_xfer;
  logic                                rot_start;
  gdvc_pkg::rot_res_t                  rot_res;
  gdvc_pkg::mac_req_t                  mac_req;
  gdvc_pkg::mac_res_t                  mac_res;
  logic signed [gdvc_pkg::EH_W-1:0]    eh;
  logic [gdvc_pkg::SPD_W-1:0]          dvx, dvy, dvw;
  logic                                reached_new;

  assign in_x = $signed(s_axis_tdata[31:0]);
  assign in_y = $signed(s_axis_tdata[63:32]);
  assign in_h = $signed(s_axis_tdata[79:64]);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign m_xfer        = m_valid_q && m_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_xfer      = cfg_valid_i && cfg_ready_o;

  assign rot_start = s_xfer && s_axis_tuser;

  gdvc_cordic u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (rot_start),
    .heading_i (in_h),
    .res_o     (rot_res)
  );

  always_comb begin
    mac_req.start = (state_q == ST_ROT) && rot_res.done;
    mac_req.sin   = rot_res.sin;
    mac_req.cos   = rot_res.cos;
    mac_req.dx    = dx_q;
    mac_req.dy    = dy_q;
  end

  gdvc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .res_o  (mac_res)
  );

  assign eh  = gdvc_pkg::EH_W'(goal_heading_q) - gdvc_pkg::EH_W'(heading_q);
  assign dvx = gdvc_pkg::drive_axis(mac_res.ex, tol_x_q, speed_set_q[15:0]);
  assign dvy = gdvc_pkg::drive_axis(mac_res.ey, tol_y_q, speed_set_q[31:16]);
  assign dvw = gdvc_pkg::drive_axis(gdvc_pkg::ERR_W'(eh), gdvc_pkg::TOL_W'(tol_heading_q),
                                    speed_set_q[47:32]);
  assign reached_new = (dvx == '0) && (dvy == '0) && (dvw == '0);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_xfer) begin
          state_d = s_axis_tuser ? ST_ROT : ST_OUT;
        end
      end
      ST_ROT: begin
        if (rot_res.done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mac_res.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      m_valid_q      <= 1'b0;
      reached_q      <= 1'b0;
      goal_x_q       <= '0;
      goal_y_q       <= '0;
      goal_heading_q <= '0;
      tol_x_q        <= '0;
      tol_y_q        <= '0;
      tol_heading_q  <= '0;
      speed_set_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && out_free) begin
        m_valid_q <= 1'b1;
        if (pv_q) begin
          reached_q <= reached_new;
        end
      end else if (m_xfer) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_xfer) begin
        case (gdvc_pkg::cfg_idx_e'(cfg_index_i))
          gdvc_pkg::REG_GOAL_X: begin
            goal_x_q  <= cfg_data_i[31:0];
            reached_q <= 1'b0;
          end
          gdvc_pkg::REG_GOAL_Y: begin
            goal_y_q  <= cfg_data_i[31:0];
            reached_q <= 1'b0;
          end
          gdvc_pkg::REG_GOAL_HEADING: begin
            goal_heading_q <= cfg_data_i[15:0];
            reached_q      <= 1'b0;
          end
          gdvc_pkg::REG_TOL_X:       tol_x_q       <= cfg_data_i[30:0];
          gdvc_pkg::REG_TOL_Y:       tol_y_q       <= cfg_data_i[30:0];
          gdvc_pkg::REG_TOL_HEADING: tol_heading_q <= cfg_data_i[15:0];
          gdvc_pkg::REG_SPEED_SET:   speed_set_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      pv_q      <= s_axis_tuser;
      heading_q <= in_h;
      dx_q      <= gdvc_pkg::DIFF_W'(goal_x_q) - gdvc_pkg::DIFF_W'(in_x);
      dy_q      <= gdvc_pkg::DIFF_W'(goal_y_q) - gdvc_pkg::DIFF_W'(in_y);
    end
    if (state_q == ST_OUT && out_free) begin
      if (pv_q) begin
        m_data_q <= {dvw, dvy, dvx};
        m_user_q <= reached_new;
      end else begin
        m_data_q <= '0;
        m_user_q <= reached_q;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  a_rot_done_in_rot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot_res.done |-> state_q == ST_ROT)
    else $error("rotator finished outside rotation phase");

  a_mac_done_in_mul : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_res.done |-> state_q == ST_MUL)
    else $error("multiplier finished outside multiply phase");

  a_reached_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata == '0)
    else $error("goal reached reported with non-zero drive");

  a_busy_after_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> state_q != ST_IDLE)
    else $error("controller idle right after taking a pose");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the goal deadband velocity controller. A directed
// table of goal, tolerance and speed settings and pose transfers (extremes,
// invalid poses, speed saturation, flag clearing, unused register index) is
// followed by random phases of reconfiguration and poses clustered around
// the goal. Each result is checked against its table value or a bit-accurate
// CORDIC and deadband predictor, with random idle bursts on both streams.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  REG_UNUSED  = 3'd7;
  localparam int          ROT_STEPS   = (gdvc_pkg::CORDIC_STEPS < 24) ?
                                        gdvc_pkg::CORDIC_STEPS : 24;
  localparam longint      PI_Q28      = 843314857;
  localparam longint      TWO_PI_Q28  = 1686629713;
  localparam longint      HALF_PI_Q28 = 421657428;
  localparam longint      GAIN_Q28    = 163008219;
  localparam logic [15:0] SPD_CAP     = 16'h7FFF;
  localparam int          STALL_LIMIT = 2000;
  localparam int          PHASES      = 14;
  localparam int          PHASE_POSES = 125;

  typedef struct packed {
    logic [15:0] drive_x;
    logic [15:0] drive_y;
    logic [15:0] drive_yaw;
    logic        reached;
  } drive_t;

  typedef struct {
    bit          cfg;
    logic [2:0]  idx;
    logic [47:0] data;
    bit          pv;
    logic [31:0] px;
    logic [31:0] py;
    logic [15:0] hd;
    bit          typed;
    drive_t      want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [79:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tready = 1'b1;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [47:0] m_tdata;
  wire         m_tuser;
  wire         cfg_ready;

  longint tgt_x = 0, tgt_y = 0, tgt_hd = 0;
  longint tol_x = 0, tol_y = 0, tol_hd = 0;
  logic [47:0] spd_set = '0;
  bit at_goal = 1'b0;
  longint atan_tab [24] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
    4193963, 2097109, 1048571, 524287, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32
  };

  drive_t    pending_drives [$];
  plan_row_t plan [$];
  int        mismatches = 0;
  int        quiet_cycles = 0;
  int        tx_gap_pct = 20;
  int        rx_stall_pct = 10;

  goal_deadband_velocity_controller dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic void body_sincos(input longint ang, output longint s, output longint c);
    longint x, y, z, t;
    bit flip;
    x = GAIN_Q28;
    y = 0;
    flip = 1'b0;
    if (ang > PI_Q28) ang -= TWO_PI_Q28;
    else if (ang < -PI_Q28) ang += TWO_PI_Q28;
    if (ang > HALF_PI_Q28) begin
      ang -= PI_Q28;
      flip = 1'b1;
    end else if (ang < -HALF_PI_Q28) begin
      ang += PI_Q28;
      flip = 1'b1;
    end
    z = ang;
    for (int i = 0; i < ROT_STEPS; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_tab[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_tab[i];
      end
      x = t;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [15:0] axis_cmd(longint err, longint tol, logic [15:0] spd);
    longint mag;
    logic [15:0] lim;
    mag = (err < 0) ? -err : err;
    lim = (spd > SPD_CAP) ? SPD_CAP : spd;
    if (mag <= tol) return '0;
    return (err > 0) ? lim : -lim;
  endfunction

  function automatic drive_t predict_pose(bit pv, logic [31:0] px, logic [31:0] py,
                                          logic [15:0] hd);
    drive_t r;
    longint h, dx, dy, s, c, ex, ey;
    r = '0;
    if (pv) begin
      h  = longint'($signed(hd));
      dx = tgt_x - longint'($signed(px));
      dy = tgt_y - longint'($signed(py));
      body_sincos(h * 65536, s, c);
      ex = (c * dx + s * dy) >>> 28;
      ey = (c * dy - s * dx) >>> 28;
      r.drive_x   = axis_cmd(ex, tol_x, spd_set[15:0]);
      r.drive_y   = axis_cmd(ey, tol_y, spd_set[31:16]);
      r.drive_yaw = axis_cmd(tgt_hd - h, tol_hd, spd_set[47:32]);
      at_goal = (r.drive_x == 0) && (r.drive_y == 0) && (r.drive_yaw == 0);
    end
    r.reached = at_goal;
    return r;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [47:0] d);
    case (idx)
      gdvc_pkg::REG_GOAL_X: begin
        tgt_x = longint'($signed(d[31:0]));
        at_goal = 1'b0;
      end
      gdvc_pkg::REG_GOAL_Y: begin
        tgt_y = longint'($signed(d[31:0]));
        at_goal = 1'b0;
      end
      gdvc_pkg::REG_GOAL_HEADING: begin
        tgt_hd = longint'($signed(d[15:0]));
        at_goal = 1'b0;
      end
      gdvc_pkg::REG_TOL_X:       tol_x = longint'(d[30:0]);
      gdvc_pkg::REG_TOL_Y:       tol_y = longint'(d[30:0]);
      gdvc_pkg::REG_TOL_HEADING: tol_hd = longint'(d[15:0]);
      gdvc_pkg::REG_SPEED_SET:   spd_set = d;
      default: ;
    endcase
  endfunction

  function automatic logic [47:0] pick_reg(logic [2:0] idx);
    logic [47:0] raw;
    int r;
    raw = {16'($urandom), $urandom};
    r = $urandom_range(0, 5);
    case (idx)
      gdvc_pkg::REG_GOAL_X, gdvc_pkg::REG_GOAL_Y: begin
        if (r == 0) raw[31:0] = 32'h7FFF_FFFF;
        else if (r == 1) raw[31:0] = 32'h8000_0000;
        else if (r < 4) raw[31:0] = {{12{raw[19]}}, raw[19:0]};
      end
      gdvc_pkg::REG_GOAL_HEADING: begin
        if (r == 0) raw[15:0] = 16'h7FFF;
        else if (r == 1) raw[15:0] = 16'h8000;
      end
      gdvc_pkg::REG_TOL_X, gdvc_pkg::REG_TOL_Y: begin
        if (r == 0) raw[30:0] = '0;
        else if (r == 1) raw[30:0] = '1;
        else raw[30:0] = 31'(raw[17:0]);
      end
      gdvc_pkg::REG_TOL_HEADING: begin
        if (r == 0) raw[15:0] = '0;
        else if (r == 1) raw[15:0] = '1;
        else raw[15:12] = '0;
      end
      gdvc_pkg::REG_SPEED_SET: if (r == 0) raw = '0;
      default: ;
    endcase
    return raw;
  endfunction

  function automatic longint jitter(longint tol);
    longint span;
    span = (tol > 64'h3FFF_FFF0) ? 64'h3FFF_FFF0 : tol + 8;
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  function automatic plan_row_t row_pose(bit pv, logic [31:0] px, logic [31:0] py,
                                         logic [15:0] hd);
    plan_row_t r;
    r = '{default: '0};
    r.pv = pv;
    r.px = px;
    r.py = py;
    r.hd = hd;
    return r;
  endfunction

  function automatic plan_row_t row_known(bit pv, logic [31:0] px, logic [31:0] py,
                                          logic [15:0] hd, logic [15:0] wx,
                                          logic [15:0] wy, logic [15:0] ww, bit wr);
    plan_row_t r;
    r = row_pose(pv, px, py, hd);
    r.typed = 1'b1;
    r.want = {wx, wy, ww, wr};
    return r;
  endfunction

  function automatic plan_row_t row_cfg(logic [2:0] idx, logic [47:0] d);
    plan_row_t r;
    r = '{default: '0};
    r.cfg = 1'b1;
    r.idx = idx;
    r.data = d;
    return r;
  endfunction

  task automatic send_pose(bit pv, logic [31:0] px, logic [31:0] py, logic [15:0] hd,
                           bit typed, drive_t want);
    drive_t predicted;
    s_tvalid <= 1'b1;
    s_tdata  <= {hd, py, px};
    s_tuser  <= pv;
    do @(posedge clk); while (!s_tready);
    predicted = predict_pose(pv, px, py, hd);
    pending_drives.push_back(typed ? want : predicted);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, d);
    cfg_valid <= 1'b0;
  endtask

  // Hold the pose stream until every pending result has been transferred.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_drives.size() != 0);
  endtask

  task automatic maybe_pause();
    if ($urandom_range(0, 99) < tx_gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic send_random_pose();
    int r;
    logic [31:0] px, py;
    logic [15:0] hd;
    r = $urandom_range(0, 99);
    px = $urandom;
    py = $urandom;
    hd = 16'($urandom);
    if (r >= 25) begin
      px = 32'(tgt_x + jitter(tol_x));
      py = 32'(tgt_y + jitter(tol_y));
      hd = 16'(tgt_hd + jitter(tol_hd));
    end
    send_pose(r >= 8, px, py, hd, 1'b0, '0);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    drive_t want;
    if (rst_n && m_tvalid && m_tready) begin
      if (pending_drives.size() == 0) begin
        $error("result transfer with no pose pending");
        mismatches++;
      end else begin
        want = pending_drives.pop_front();
        check_field("drive_x", want.drive_x, m_tdata[15:0]);
        check_field("drive_y", want.drive_y, m_tdata[31:16]);
        check_field("drive_yaw", want.drive_yaw, m_tdata[47:32]);
        check_field("arrived", {15'd0, want.reached}, {15'd0, m_tuser});
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) < rx_stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    plan.push_back(row_known(1'b0, '0, '0, '0, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    plan.push_back(row_known(1'b1, '0, '0, '0, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    plan.push_back(row_known(1'b0, '1, '1, '1, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    // zero speed: far from the goal yet every axis stays at zero
    plan.push_back(row_known(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000,
                             16'h0000, 16'h0000, 16'h0000, 1'b1));
    plan.push_back(row_cfg(gdvc_pkg::REG_SPEED_SET, 48'hFFFF_8000_1234));
    plan.push_back(row_known(1'b1, '0, '0, '0, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    plan.push_back(row_pose(1'b1, 32'hFFFF_0000, '0, '0));
    plan.push_back(row_known(1'b1, '0, '0, 16'h7FFF, 16'h0000, 16'h0000, 16'h8001, 1'b0));
    plan.push_back(row_known(1'b1, '0, '0, 16'h8000, 16'h0000, 16'h0000, 16'h7FFF, 1'b0));
    plan.push_back(row_cfg(gdvc_pkg::REG_GOAL_X, 48'hABCD_7FFF_FFFF));
    plan.push_back(row_cfg(gdvc_pkg::REG_GOAL_Y, 48'h0000_8000_0000));
    plan.push_back(row_cfg(gdvc_pkg::REG_GOAL_HEADING, 48'h5555_5555_8000));
    plan.push_back(row_pose(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF));
    plan.push_back(row_pose(1'b1, '0, '0, 16'h4000));
    plan.push_back(row_pose(1'b1, '0, '0, 16'hC000));
    plan.push_back(row_pose(1'b1, 32'h0001_0000, 32'hFFFF_8000, 16'h3244));
    plan.push_back(row_pose(1'b1, 32'h0123_4567, 32'h89AB_CDEF, 16'h1922));
    plan.push_back(row_pose(1'b1, 32'hFEDC_BA98, 32'h7654_3210, 16'hE6DE));
    plan.push_back(row_cfg(gdvc_pkg::REG_TOL_X, 48'hFFFF_FFFF_FFFF));
    plan.push_back(row_cfg(gdvc_pkg::REG_TOL_Y, 48'hFFFF_FFFF_FFFF));
    plan.push_back(row_cfg(gdvc_pkg::REG_TOL_HEADING, 48'hFFFF_FFFF_FFFF));
    plan.push_back(row_cfg(gdvc_pkg::REG_GOAL_X, 48'hFFFF_0000_0000));
    plan.push_back(row_cfg(gdvc_pkg::REG_GOAL_Y, 48'hFFFF_0000_0000));
    plan.push_back(row_cfg(gdvc_pkg::REG_GOAL_HEADING, 48'hFFFF_FFFF_0000));
    plan.push_back(row_known(1'b1, '0, '0, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    // a tolerance write leaves the reached flag alone
    plan.push_back(row_cfg(gdvc_pkg::REG_TOL_Y, 48'hFFFF_8000_0000));
    plan.push_back(row_known(1'b0, '1, '0, '1, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    // a goal write clears it
    plan.push_back(row_cfg(gdvc_pkg::REG_GOAL_HEADING, 48'h1234_5678_0000));
    plan.push_back(row_known(1'b0, '0, '1, '0, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    plan.push_back(row_cfg(REG_UNUSED, 48'hFFFF_FFFF_FFFF));
    plan.push_back(row_known(1'b1, '0, '0, '0, 16'h0000, 16'h0000, 16'h0000, 1'b1));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].cfg) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        maybe_pause();
        send_pose(plan[i].pv, plan[i].px, plan[i].py, plan[i].hd, plan[i].typed,
                  plan[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      // drop idling on every fourth phase and on the closing stretch
      tx_gap_pct   = (ph % 4 == 3 || ph >= PHASES - 2) ? 0 : 20;
      rx_stall_pct = (ph % 4 == 3 || ph >= PHASES - 2) ? 0 : 10;
      for (int k = 0; k < 8; k++) begin
        if ((ph == 0) ? (k != REG_UNUSED) : ($urandom_range(0, 2) == 0)) begin
          settle();
          write_reg(3'(k), pick_reg(3'(k)));
        end
      end
      for (int n = 0; n < PHASE_POSES; n++) begin
        maybe_pause();
        send_random_pose();
      end
    end

    settle();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
